// ===== sv/cmg_pkg.sv =====
package cmg_pkg;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOSOL = 2'd1;
	localparam logic [1:0] ST_OVF   = 2'd2;

	// Command to the shared arithmetic unit.
	typedef struct packed {
		logic start;       // load operands and begin a pass
		logic bit_from_a;  // Horner bit from operand a, else from the quotient
	} cmg_cmd_t;

	// Response of the shared arithmetic unit.
	typedef struct packed {
		logic done;        // one-cycle pulse after the last step of a pass
	} cmg_res_t;

endpackage

// ===== sv/cmg_unit.sv =====
// Bit-serial arithmetic unit. Each pass takes W steps, one bit per cycle, and does
// three things at once: a restoring division a / b, a Horner accumulation of
// (bits * c) mod n, and an exact product of the bits with c.
module cmg_unit import cmg_pkg::*; #(
	parameter int W = 62
) (
	input  logic           clk,
	input  logic           arst_n,
	input  cmg_cmd_t       cmd,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	input  logic [W-1:0]   c,
	input  logic [W-1:0]   n,
	output cmg_res_t       res,
	output logic [W-1:0]   quot,
	output logic [W-1:0]   rem,
	output logic [W-1:0]   horn,
	output logic [2*W-1:0] prod
);

	localparam int CW = $clog2(W + 1);

	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	logic           from_a_q;
	logic [W-1:0]   sh_q;
	logic [W-1:0]   rem_q;
	logic [W-1:0]   t_q;
	logic [2*W-1:0] prod_q;
	logic [W-1:0]   b_q;
	logic [W-1:0]   c_q;
	logic [W-1:0]   n_q;

	logic [W:0]     rw;
	logic           ge;
	logic [W:0]     rw_sub;
	logic           hb;
	logic [W:0]     d2;
	logic [W:0]     d2_sub;
	logic [W-1:0]   t2;
	logic [W:0]     s;
	logic [W:0]     s_sub;
	logic [W-1:0]   t3;
	logic [2*W-1:0] prod_n;

	// One restoring division step, one modular Horner step and one product step.
	always_comb begin
		rw     = {rem_q, sh_q[W-1]};
		rw_sub = rw - {1'b0, b_q};
		ge     = (rw >= {1'b0, b_q});
		hb     = from_a_q ? sh_q[W-1] : ge;
		d2     = {t_q, 1'b0};
		d2_sub = d2 - {1'b0, n_q};
		t2     = (d2 >= {1'b0, n_q}) ? d2_sub[W-1:0] : d2[W-1:0];
		s      = {1'b0, t2} + (hb ? {1'b0, c_q} : {(W + 1){1'b0}});
		s_sub  = s - {1'b0, n_q};
		t3     = (s >= {1'b0, n_q}) ? s_sub[W-1:0] : s[W-1:0];
		prod_n = {prod_q[2*W-2:0], 1'b0} + (hb ? {{W{1'b0}}, c_q} : {(2 * W){1'b0}});
	end

	// Control of the pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				cnt_q  <= CW'(W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			from_a_q <= cmd.bit_from_a;
			sh_q     <= a;
			b_q      <= b;
			c_q      <= c;
			n_q      <= n;
			rem_q    <= '0;
			t_q      <= '0;
			prod_q   <= '0;
		end else if (busy_q) begin
			sh_q   <= {sh_q[W-2:0], ge};
			rem_q  <= ge ? rw_sub[W-1:0] : rw[W-1:0];
			t_q    <= t3;
			prod_q <= prod_n;
		end
	end

	assign res.done = done_q;
	assign quot     = sh_q;
	assign rem      = rem_q;
	assign horn     = t_q;
	assign prod     = prod_q;

endmodule

// ===== sv/congruence_merge_general.sv =====
// Each item is first reduced by its own modulus in one pass of the unit; a first item, or any
// item while the system has failed, then completes. Otherwise the unit runs Euclid steps on
// the two moduli and further passes. The block works on one item at a time on the single
// bit-serial unit; in_ready is high only while idle.
// Reset: arst_n clears the running pair to 0 mod 1 with status ok and empties the output.
module congruence_merge_general import cmg_pkg::*; #(
	parameter int VALUE_WIDTH = 62
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   first_item,
	input  logic [VALUE_WIDTH-1:0] remainder,
	input  logic [VALUE_WIDTH-1:0] modulus,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [VALUE_WIDTH-1:0] combined_remainder,
	output logic [VALUE_WIDTH-1:0] combined_modulus,
	output logic [1:0]             status
);

	localparam int W = VALUE_WIDTH;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RED  = 4'd1;
	localparam logic [3:0] S_ECHK = 4'd2;
	localparam logic [3:0] S_EUC  = 4'd3;
	localparam logic [3:0] S_RM   = 4'd4;
	localparam logic [3:0] S_DG   = 4'd5;
	localparam logic [3:0] S_V    = 4'd6;
	localparam logic [3:0] S_P    = 4'd7;
	localparam logic [3:0] S_W    = 4'd8;
	localparam logic [3:0] S_L    = 4'd9;
	localparam logic [3:0] S_R    = 4'd10;
	localparam logic [3:0] S_FIN  = 4'd11;

	logic [3:0]     state_q;
	cmg_cmd_t       cmd_q;
	cmg_res_t       res;
	logic [W-1:0]   a_q, b_q, c_q, n_q;
	logic [W-1:0]   quot, rem, horn;
	logic [2*W-1:0] prod;

	logic           first_q;
	logic [W-1:0]   r2_q, m2_q, r0_q, r1_q, s0_q, s1_q, dq_q, v_q, w_q, lcm_q;
	logic [W-1:0]   acc_rem_q, acc_mod_q;
	logic [1:0]     fail_q;
	logic           out_valid_q;
	logic [W-1:0]   out_rem_q, out_mod_q;
	logic [1:0]     out_st_q;

	logic [W-1:0]   s_next;
	logic [W-1:0]   diff;
	logic           start_d;

	cmg_unit #(.W(W)) u_unit (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_q),
		.a     (a_q),
		.b     (b_q),
		.c     (c_q),
		.n     (n_q),
		.res   (res),
		.quot  (quot),
		.rem   (rem),
		.horn  (horn),
		.prod  (prod)
	);

	// New Bezout coefficient and the remainder difference, both modulo the new modulus.
	always_comb begin
		s_next = (s0_q >= horn) ? (s0_q - horn) : (s0_q + m2_q - horn);
		diff   = (r2_q >= rem) ? (r2_q - rem) : (r2_q + m2_q - rem);
	end

	// A new pass of the shared unit starts wherever the sequencer loads fresh operands.
	always_comb begin
		unique case (state_q)
			S_IDLE:                start_d = in_valid;
			S_ECHK:                start_d = 1'b1;
			S_RM, S_V, S_P, S_W:   start_d = res.done;
			S_DG:                  start_d = res.done && (rem == '0);
			S_L:                   start_d = res.done && (prod[2*W-1:W] == '0);
			default:               start_d = 1'b0;
		endcase
	end

	// Sequencer over the shared unit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= '0;
			acc_rem_q   <= '0;
			acc_mod_q   <= {{(W - 1){1'b0}}, 1'b1};
			fail_q      <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			cmd_q.start <= start_d;
			if (out_valid_q && out_ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						first_q          <= first_item;
						m2_q             <= (modulus == '0) ? {{(W - 1){1'b0}}, 1'b1} : modulus;
						a_q              <= remainder;
						b_q              <= (modulus == '0) ? {{(W - 1){1'b0}}, 1'b1} : modulus;
						cmd_q.bit_from_a <= 1'b0;
						state_q          <= S_RED;
					end
				end
				S_RED: begin
					if (res.done) begin
						r2_q <= rem;
						if (first_q) begin
							acc_rem_q <= rem;
							acc_mod_q <= m2_q;
							fail_q    <= ST_OK;
							state_q   <= S_FIN;
						end else if (fail_q != ST_OK) begin
							state_q <= S_FIN;
						end else begin
							r0_q    <= acc_mod_q;
							r1_q    <= m2_q;
							s0_q    <= (m2_q == {{(W - 1){1'b0}}, 1'b1}) ? '0
								: {{(W - 1){1'b0}}, 1'b1};
							s1_q    <= '0;
							state_q <= S_ECHK;
						end
					end
				end
				S_ECHK: begin
					cmd_q.bit_from_a <= 1'b0;
					if (r1_q == '0) begin
						// gcd found in r0; reduce the running remainder by the new modulus.
						a_q     <= acc_rem_q;
						b_q     <= m2_q;
						state_q <= S_RM;
					end else begin
						a_q     <= r0_q;
						b_q     <= r1_q;
						c_q     <= s1_q;
						n_q     <= m2_q;
						state_q <= S_EUC;
					end
				end
				S_EUC: begin
					if (res.done) begin
						r0_q    <= r1_q;
						r1_q    <= rem;
						s0_q    <= s1_q;
						s1_q    <= s_next;
						state_q <= S_ECHK;
					end
				end
				S_RM: begin
					if (res.done) begin
						a_q              <= diff;
						b_q              <= r0_q;
						cmd_q.bit_from_a <= 1'b0;
						state_q          <= S_DG;
					end
				end
				S_DG: begin
					if (res.done) begin
						if (rem != '0) begin
							fail_q    <= ST_NOSOL;
							acc_rem_q <= '0;
							acc_mod_q <= {{(W - 1){1'b0}}, 1'b1};
							state_q   <= S_FIN;
						end else begin
							dq_q             <= quot;
							a_q              <= m2_q;
							b_q              <= r0_q;
							cmd_q.bit_from_a <= 1'b0;
							state_q          <= S_V;
						end
					end
				end
				S_V: begin
					if (res.done) begin
						v_q              <= quot;
						a_q              <= s0_q;
						b_q              <= quot;
						cmd_q.bit_from_a <= 1'b0;
						state_q          <= S_P;
					end
				end
				S_P: begin
					if (res.done) begin
						// Multiply the reduced difference by the inverse, modulo v.
						a_q              <= dq_q;
						c_q              <= rem;
						n_q              <= v_q;
						cmd_q.bit_from_a <= 1'b1;
						state_q          <= S_W;
					end
				end
				S_W: begin
					if (res.done) begin
						w_q              <= horn;
						a_q              <= v_q;
						c_q              <= acc_mod_q;
						cmd_q.bit_from_a <= 1'b1;
						state_q          <= S_L;
					end
				end
				S_L: begin
					if (res.done) begin
						if (prod[2*W-1:W] != '0) begin
							fail_q    <= ST_OVF;
							acc_rem_q <= '0;
							acc_mod_q <= {{(W - 1){1'b0}}, 1'b1};
							state_q   <= S_FIN;
						end else begin
							lcm_q            <= prod[W-1:0];
							a_q              <= w_q;
							c_q              <= acc_mod_q;
							cmd_q.bit_from_a <= 1'b1;
							state_q          <= S_R;
						end
					end
				end
				S_R: begin
					if (res.done) begin
						acc_rem_q <= acc_rem_q + prod[W-1:0];
						acc_mod_q <= lcm_q;
						state_q   <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register, loaded as the item completes.
	always_ff @(posedge clk) begin
		if (state_q == S_FIN && (!out_valid_q || out_ready)) begin
			out_st_q  <= fail_q;
			out_rem_q <= (fail_q == ST_OK) ? acc_rem_q : '0;
			out_mod_q <= (fail_q == ST_OK) ? acc_mod_q : '0;
		end
	end

	assign in_ready           = (state_q == S_IDLE);
	assign out_valid          = out_valid_q;
	assign combined_remainder = out_rem_q;
	assign combined_modulus   = out_mod_q;
	assign status             = out_st_q;

endmodule

// ===== sv/cmg_checker.sv =====
module cmg_checker import cmg_pkg::*; #(
	parameter int VALUE_WIDTH = 62
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [VALUE_WIDTH-1:0] combined_remainder,
	input logic [VALUE_WIDTH-1:0] combined_modulus,
	input logic [1:0]             status
);

	// A stalled result holds still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(combined_remainder)
			&& $stable(combined_modulus) && $stable(status))
		else $error("stalled result changed");

	// Only one item is in work: after an input transfer the block is busy.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// A failed system shows both value fields as zero.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> combined_remainder == '0 && combined_modulus == '0)
		else $error("failed result carries values");

	// A good result is reduced and has a nonzero modulus.
	a_ok_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> combined_modulus != '0
			&& combined_remainder < combined_modulus)
		else $error("result not reduced");

	// Status is one of the three codes.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_OK || status == ST_NOSOL || status == ST_OVF)
		else $error("undefined status code");

endmodule

bind congruence_merge_general cmg_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_cmg_checker (.*);
